// ----- rtl/core/positional_list_insert_delete_defines.svh -----
// assertion macros for the positional list block
// used by the top level only; needs nothing else
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

// property that holds at every clock edge outside reset
`define PLID_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("plid assertion failed");

// same-cycle implication outside reset
`define PLID_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plid assertion failed");

`endif

// ----- rtl/core/plid_pkg.sv -----
// shared types, codes and sizes of the positional list block
// no dependencies; imported by every module of the block
`default_nettype none

package plid_pkg;

    // list storage
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // field widths
    localparam int KIND_W = 2;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int CAP_W  = 5;
    localparam int ST_W   = 2;
    localparam int IN_TDATA_W = ((VAL_W + POS_W + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // derived counter widths
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // command kinds on the input
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_DUMP
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] element;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             busy;
    } t_back_stat;

endpackage

`default_nettype wire

// ----- rtl/core/plid_front.sv -----
// front end: takes input items, decodes the kind and registers the command
// depends on plid_pkg
`default_nettype none

module plid_front
    import plid_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [VAL_W-1:0]  i_value,
    input  wire logic [POS_W-1:0]  i_pos,
    output logic                   o_push,
    output t_cmd                   o_cmd,
    input  wire logic              i_q_ready
);

    logic r_valid;
    t_cmd r_cmd;
    logic accept;
    logic n_known;
    t_op  n_op;

    // free when empty or when the held command leaves this cycle
    assign o_ready = !r_valid || i_q_ready;
    assign accept  = i_valid && o_ready;

    // decode the kind; unused code is dropped here
    always_comb begin
        n_known = 1'b1;
        n_op    = OP_INSERT;
        case (i_kind)
            KIND_INSERT: n_op = OP_INSERT;
            KIND_DELETE: n_op = OP_DELETE;
            KIND_DUMP:   n_op = OP_DUMP;
            default:     n_known = 1'b0;
        endcase
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= n_known;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.op    <= n_op;
            r_cmd.value <= i_value;
            r_cmd.pos   <= i_pos;
        end
    end

    assign o_push = r_valid;
    assign o_cmd  = r_cmd;

endmodule

`default_nettype wire

// ----- rtl/core/plid_queue.sv -----
// short command queue between front and back end
// depends on plid_pkg
`default_nettype none

module plid_queue
    import plid_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_ready,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_valid
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/plid_back.sv -----
// back end: holds the list, runs insert, delete and dump, drives results
// depends on plid_pkg
`default_nettype none

module plid_back
    import plid_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    input  wire logic             i_q_valid,
    input  t_cmd                  i_q_cmd,
    output logic                  o_q_pop,
    output logic                  o_res_valid,
    output t_result               o_res,
    input  wire logic             i_res_ready,
    output t_back_stat            o_stat
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_count;
    logic [CAP_W-1:0]      r_capacity;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_res_valid;
    t_result               r_res;
    logic [DATA_WIDTH-1:0] r_entries [DEPTH];
    logic [DATA_WIDTH-1:0] n_entries [DEPTH];
    logic [DATA_WIDTH-1:0] w_prev    [DEPTH];
    logic [DATA_WIDTH-1:0] w_next    [DEPTH];

    logic [CMP_W-1:0] w_cnt;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cap;
    logic [CMP_W-1:0] w_limit;
    logic [63:0]      w_value64;
    logic [63:0]      w_elem64;
    logic [DATA_WIDTH-1:0] w_value;
    logic [ST_W-1:0]  n_status;
    logic out_free;
    logic ins_ovf;
    logic ins_rng;
    logic del_rng;
    logic do_ins;
    logic do_del;
    logic dump_go;
    logic dump_last;

    // widened operands for the checks
    assign w_cnt   = CMP_W'(r_count);
    assign w_pos   = CMP_W'(i_q_cmd.pos);
    assign w_cap   = CMP_W'(r_capacity);
    assign w_limit = (w_cap < CMP_W'(DEPTH)) ? w_cap : CMP_W'(DEPTH);

    assign ins_ovf = (w_cnt >= w_limit);
    assign ins_rng = (w_pos == '0) || (w_pos > w_cnt + CMP_W'(1));
    assign del_rng = (w_pos == '0) || (w_pos > w_cnt);

    // output slot is free when empty or being taken
    assign out_free = !r_res_valid || i_res_ready;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid && out_free;

    assign do_ins  = o_q_pop && (i_q_cmd.op == OP_INSERT) && !ins_ovf && !ins_rng;
    assign do_del  = o_q_pop && (i_q_cmd.op == OP_DELETE) && !del_rng;
    assign dump_go = o_q_pop && (i_q_cmd.op == OP_DUMP) && (r_count != '0);

    // status of the single result of a popped command
    always_comb begin
        n_status = ST_OK;
        case (i_q_cmd.op)
            OP_INSERT: begin
                if (ins_ovf) begin
                    n_status = ST_OVERFLOW;
                end else if (ins_rng) begin
                    n_status = ST_RANGE;
                end
            end
            OP_DELETE: begin
                if (del_rng) begin
                    n_status = ST_RANGE;
                end
            end
            OP_DUMP: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // value and element width fitting
    assign w_value64 = 64'(i_q_cmd.value);
    assign w_value   = w_value64[DATA_WIDTH-1:0];
    assign w_elem64  = 64'(r_entries[r_idx]);
    assign dump_last = (CMP_W'(r_idx) + CMP_W'(1)) == w_cnt;

    // neighbor taps of each lane
    for (genvar g = 0; g < DEPTH; g++) begin : g_lane
        if (g == 0) begin : g_first
            assign w_prev[g] = '0;
        end else begin : g_mid_prev
            assign w_prev[g] = r_entries[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next[g] = '0;
        end else begin : g_mid_next
            assign w_next[g] = r_entries[g+1];
        end
    end

    // parallel shift for insert and delete
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entries[i] = r_entries[i];
            if (do_ins) begin
                if (CMP_W'(i) == w_pos - CMP_W'(1)) begin
                    n_entries[i] = w_value;
                end else if (CMP_W'(i) > w_pos - CMP_W'(1) && CMP_W'(i) <= w_cnt) begin
                    n_entries[i] = w_prev[i];
                end
            end else if (do_del) begin
                if (CMP_W'(i) >= w_pos - CMP_W'(1) && CMP_W'(i) + CMP_W'(1) < w_cnt) begin
                    n_entries[i] = w_next[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_ins || do_del) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_entries[i] <= n_entries[i];
            end
        end
    end

    // sequencer, count, capacity and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_idx       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_capacity <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        // a non-empty dump sends its items from the dump state
                        r_res_valid   <= !dump_go;
                        r_res.status  <= n_status;
                        r_res.element <= '0;
                        r_res.last    <= 1'b1;
                        if (do_ins) begin
                            r_count <= r_count + CNT_W'(1);
                        end else if (do_del) begin
                            r_count <= r_count - CNT_W'(1);
                        end
                        if (dump_go) begin
                            r_idx   <= '0;
                            r_state <= S_DUMP;
                        end
                    end else if (i_res_ready) begin
                        r_res_valid <= 1'b0;
                    end
                end
                S_DUMP: begin
                    if (out_free) begin
                        r_res_valid   <= 1'b1;
                        r_res.status  <= ST_OK;
                        r_res.element <= w_elem64[VAL_W-1:0];
                        r_res.last    <= dump_last;
                        if (dump_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid  = r_res_valid;
    assign o_res        = r_res;
    assign o_stat.count = r_count;
    assign o_stat.busy  = (r_state == S_DUMP);

endmodule

`default_nettype wire

// ----- rtl/core/positional_list_insert_delete.sv -----
// Positional list of up to 16 signed 32-bit entries. Each input item is one
// command: insert a value at a 1-based position, delete the entry at a
// position, or dump the whole list. Insert and delete give one result item
// with a status; dump gives one item per entry (tlast on the final one), or
// a single list-empty status. Kind code 3 is dropped with no result. A front
// stage decodes commands into a two-entry queue; the back end owns the list
// and shifts all entries in parallel, so insert and delete each update the
// whole list at once, and a dump makes one read
// of the entry array per result. The capacity register (reset 16) may only
// be written while the block is idle; lowering it keeps entries already held.
// depends on plid_pkg, plid_front, plid_queue, plid_back and the defines header
`default_nettype none

`include "positional_list_insert_delete_defines.svh"

module positional_list_insert_delete
    import plid_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write: capacity
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CAP_W-1:0]      i_cfg_data,
    // command items
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,  // value[31:0], position[36:32], pad
    input  wire logic [KIND_W-1:0]     s_axis_tuser,  // kind[1:0]
    // result items
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [VAL_W-1:0]           m_axis_tdata,  // element[31:0]
    output logic [ST_W-1:0]            m_axis_tuser,  // status[1:0]
    output logic                       m_axis_tlast
);

    logic       push;
    t_cmd       front_cmd;
    logic       q_ready;
    logic       q_valid;
    t_cmd       q_cmd;
    logic       q_pop;
    t_result    res;
    t_back_stat stat;

    assign o_cfg_ready = 1'b1;

    // decode and register incoming commands
    plid_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_kind    (s_axis_tuser),
        .i_value   (s_axis_tdata[VAL_W-1:0]),
        .i_pos     (s_axis_tdata[VAL_W+POS_W-1:VAL_W]),
        .o_push    (push),
        .o_cmd     (front_cmd),
        .i_q_ready (q_ready)
    );

    // decoupling queue
    plid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_valid (q_valid)
    );

    // list storage and execution
    plid_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (m_axis_tready),
        .o_stat      (stat)
    );

    assign m_axis_tdata = res.element;
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;

    // checks
    `PLID_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, stat.count <= CNT_W'(DEPTH))
    `PLID_ASSERT_IMPLIES(a_dump_nonempty, i_clk, i_rst_n, stat.busy, stat.count != '0)
    `PLID_ASSERT_IMPLIES(a_status_single, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tlast && (m_axis_tdata == '0))

endmodule

`default_nettype wire
